// ===== hw/rtl/modinv_pkg.sv =====
// Shared types for the modular inverse unit.
// No dependencies; imported by modinv_div and modular_inverse_unit.
`default_nettype none

package modinv_pkg;

    // status of the serial divide/accumulate unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/modular_inverse_unit.sv =====
// Steps: input capture, Euclid rounds (check and divide), final reduction modulo m, output load;
// moduli 0 and 1, and items with no inverse after the rounds, skip the final reduction.
// Each round uses the serial divider: one quotient bit per cycle.
// Throughput: one item at a time; a new item is taken once the previous result is loaded.
// Reset: synchronous active-low i_rst_n clears the controller and output valid.
// Top level of the modular inverse unit; uses modinv_pkg and modinv_div.
`default_nettype none

module modular_inverse_unit #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [WIDTH-1:0] i_value,
    input  wire logic [WIDTH-1:0] i_modulus,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic      [WIDTH-1:0] o_inverse,
    output logic                  o_exists
);
    import modinv_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_MOD    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [WIDTH-1:0] r_a, r_b, r_m, r_cur, r_nxt;
    logic [WIDTH-1:0] n_a, n_b, n_m, n_cur, n_nxt;
    logic             r_neg, n_neg;
    logic [WIDTH-1:0] r_res, n_res;
    logic             r_res_ok, n_res_ok;
    logic             r_out_valid, n_out_valid;
    logic [WIDTH-1:0] r_inverse, n_inverse;
    logic             r_exists, n_exists;

    logic             div_start;
    logic [WIDTH-1:0] div_dividend, div_divisor, div_mult;
    logic [WIDTH-1:0] div_rem, div_prod;
    t_div_stat        div_stat;

    logic in_take, out_take;

    assign o_stall  = (r_state != ST_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;

    modinv_div #(.WIDTH(WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_mult     (div_mult),
        .o_rem      (div_rem),
        .o_prod     (div_prod),
        .o_stat     (div_stat)
    );

    always_comb begin
        n_state      = r_state;
        n_a          = r_a;
        n_b          = r_b;
        n_m          = r_m;
        n_cur        = r_cur;
        n_nxt        = r_nxt;
        n_neg        = r_neg;
        n_res        = r_res;
        n_res_ok     = r_res_ok;
        n_out_valid  = r_out_valid && !out_take;
        n_inverse    = r_inverse;
        n_exists     = r_exists;
        div_start    = 1'b0;
        div_dividend = r_a;
        div_divisor  = r_b;
        div_mult     = r_nxt;

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_a   = i_value;
                    n_b   = i_modulus;
                    n_m   = i_modulus;
                    n_cur = WIDTH'(1);
                    n_nxt = '0;
                    n_neg = 1'b0;
                    if (i_modulus == WIDTH'(1)) begin
                        n_res    = WIDTH'(1);
                        n_res_ok = 1'b1;
                        n_state  = ST_FINISH;
                    end else if (i_modulus == '0) begin
                        n_res    = '0;
                        n_res_ok = 1'b0;
                        n_state  = ST_FINISH;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (r_a > WIDTH'(1) && r_b != '0) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else if (r_a != WIDTH'(1)) begin
                    n_res    = '0;
                    n_res_ok = 1'b0;
                    n_state  = ST_FINISH;
                end else begin
                    // reduce the coefficient modulo m
                    div_start    = 1'b1;
                    div_dividend = r_cur;
                    div_divisor  = r_m;
                    div_mult     = '0;
                    n_state      = ST_MOD;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_a     = r_b;
                    n_b     = div_rem;
                    n_cur   = r_nxt;
                    n_nxt   = r_cur + div_prod;
                    n_neg   = !r_neg;
                    n_state = ST_CHECK;
                end
            end
            ST_MOD: begin
                if (div_stat.done) begin
                    n_res    = (r_neg && div_rem != '0) ? (r_m - div_rem) : div_rem;
                    n_res_ok = 1'b1;
                    n_state  = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    n_inverse   = r_res;
                    n_exists    = r_res_ok;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_m       <= n_m;
        r_cur     <= n_cur;
        r_nxt     <= n_nxt;
        r_neg     <= n_neg;
        r_res     <= n_res;
        r_res_ok  <= n_res_ok;
        r_inverse <= n_inverse;
        r_exists  <= n_exists;
    end

    assign o_valid   = r_out_valid;
    assign o_inverse = r_inverse;
    assign o_exists  = r_exists;

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_exists) |-> (r_inverse == '0))
        else $error("no-inverse item carries a nonzero value");

    a_div_only_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == ST_DIV || r_state == ST_MOD))
        else $error("divider busy outside a round or reduction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=>
            (r_out_valid && $stable(r_inverse) && $stable(r_exists)))
        else $error("stalled result item changed or dropped");

endmodule

`default_nettype wire

// ===== hw/rtl/modinv_div.sv =====
// Radix-2 serial divider with a shift-add product of the quotient.
// One quotient bit per cycle, MSB first; uses modinv_pkg.
`default_nettype none

module modinv_div #(
    parameter int WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [WIDTH-1:0]       i_dividend,
    input  wire logic [WIDTH-1:0]       i_divisor,
    input  wire logic [WIDTH-1:0]       i_mult,
    output logic      [WIDTH-1:0]       o_rem,
    output logic      [WIDTH-1:0]       o_prod,
    output modinv_pkg::t_div_stat       o_stat
);
    import modinv_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic            r_busy, r_done;
    logic [CW-1:0]   r_cnt;
    logic [WIDTH-1:0] r_rem, r_dq, r_div, r_mult, r_prod;

    logic [WIDTH:0]   shifted;
    logic             qbit;
    logic [WIDTH:0]   diff;
    logic [WIDTH-1:0] n_rem, n_prod;

    always_comb begin
        shifted = {r_rem, r_dq[WIDTH-1]};
        qbit    = (shifted >= {1'b0, r_div});
        diff    = shifted - {1'b0, r_div};
        // partial remainder stays below the divisor, so it fits WIDTH bits
        n_rem   = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        // q * mult mod 2^WIDTH, Horner form over quotient bits
        n_prod  = {r_prod[WIDTH-2:0], 1'b0} + (qbit ? r_mult : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dq   <= i_dividend;
            r_div  <= i_divisor;
            r_mult <= i_mult;
            r_prod <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_dq   <= {r_dq[WIDTH-2:0], qbit};
            r_prod <= n_prod;
        end
    end

    assign o_rem       = r_rem;
    assign o_prod      = r_prod;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a preceding busy step");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

endmodule

`default_nettype wire

// ===== dv/modular_inverse_unit_test.sv =====
// Self-checking testbench for modular_inverse_unit: directed and random items, with the
// results checked against an extended-Euclid predictor kept in this file.
// Depends on hw/rtl/modinv_pkg.sv, the divider and hw/rtl/modular_inverse_unit.sv.

module modular_inverse_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH       = 32;
    localparam int CYCLE_LIMIT = 2_500_000;
    localparam int DRAIN_WAIT  = 2000;   // above the worst-case latency of one item
    localparam int HOLD_CYCLES = 5000;
    localparam int HOLD_AFTER  = 40;
    localparam int RANDOM_ITEMS = 300;

    typedef struct {
        logic [WIDTH-1:0] value;
        logic [WIDTH-1:0] modulus;
        bit               wait_drain;   // sender holds this item until all results are back
    } t_operand;

    typedef struct {
        logic [WIDTH-1:0] inverse;
        logic             exists;
    } t_inverse;

    typedef enum int {RX_OPEN, RX_HALF, RX_LIGHT, RX_HEAVY} t_rx_mode;

    logic             i_clk;
    logic             i_rst_n   = 1'b0;
    logic             i_valid   = 1'b0;
    logic [WIDTH-1:0] i_value   = '0;
    logic [WIDTH-1:0] i_modulus = '0;
    logic             i_stall   = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [WIDTH-1:0] o_inverse;
    logic             o_exists;

    t_operand operand_queue[$];
    t_inverse inverse_due[$];

    int       cycle_count  = 0;
    int       error_count  = 0;
    int       results_seen = 0;
    int       burst_left   = 0;
    int       gap_left     = 0;
    int       hold_left    = 0;
    bit       hold_done    = 1'b0;
    int       seg_left     = 0;
    t_rx_mode rx_mode      = RX_OPEN;

    logic [WIDTH-1:0] fib [0:47];

    modular_inverse_unit #(.WIDTH(WIDTH)) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_value   (i_value),
        .i_modulus (i_modulus),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_inverse (o_inverse),
        .o_exists  (o_exists)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Extended Euclid keeping the magnitude of the value's coefficient; its sign flips
    // every round.
    function automatic t_inverse mod_inverse_of(input logic [WIDTH-1:0] value,
                                                input logic [WIDTH-1:0] modulus);
        bit [WIDTH-1:0] rem_a, rem_b, coef_a, coef_b, quo, rem, coef_n;
        bit             negative;
        t_inverse       res;
        rem_a    = value;
        rem_b    = modulus;
        coef_a   = 1;
        coef_b   = 0;
        negative = 1'b0;
        res.inverse = '0;
        res.exists  = 1'b0;
        if (modulus == 1) begin
            res.inverse = 1;
            res.exists  = 1'b1;
            return res;
        end
        if (modulus == 0)
            return res;
        while (rem_a > 1 && rem_b != 0) begin
            quo    = rem_a / rem_b;
            rem    = rem_a % rem_b;
            coef_n = coef_a + quo * coef_b;
            rem_a  = rem_b;
            rem_b  = rem;
            coef_a = coef_b;
            coef_b = coef_n;
            negative = ~negative;
        end
        if (rem_a != 1)
            return res;
        coef_a = coef_a % modulus;
        if (negative && coef_a != 0)
            coef_a = modulus - coef_a;
        res.inverse = coef_a;
        res.exists  = 1'b1;
        return res;
    endfunction

    task automatic add_item(input logic [WIDTH-1:0] value, input logic [WIDTH-1:0] modulus,
                            input bit wait_drain);
        t_operand op;
        op.value      = value;
        op.modulus    = modulus;
        op.wait_drain = wait_drain;
        operand_queue.push_back(op);
    endtask

    task automatic flag_error(input string msg);
        if (error_count < 10)
            $display("%s", msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // driver: bursts of items separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                inverse_due.push_back(mod_inverse_of(i_value, i_modulus));
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left = 0;
                        9:       gap_left = $urandom_range(200, 2500);
                        default: gap_left = $urandom_range(1, 40);
                    endcase
                end
            end
            if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (operand_queue.size() != 0 &&
                         !(operand_queue[0].wait_drain && inverse_due.size() != 0)) begin
                i_value   <= operand_queue[0].value;
                i_modulus <= operand_queue[0].modulus;
                i_valid   <= 1'b1;
                void'(operand_queue.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // one long hold on the result side, so the block backs up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: check each accepted result, then pick the next stall
    always @(posedge i_clk) begin
        t_inverse want;
        bit       pat;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            if (inverse_due.size() == 0) begin
                flag_error($sformatf("unexpected result: inverse %h exists %b",
                                     o_inverse, o_exists));
            end else begin
                want = inverse_due.pop_front();
                if (o_inverse !== want.inverse || o_exists !== want.exists)
                    flag_error($sformatf(
                        "mismatch: expected inverse %h exists %b, got inverse %h exists %b",
                        want.inverse, want.exists, o_inverse, o_exists));
            end
        end
        if (seg_left == 0) begin
            rx_mode  = t_rx_mode'($urandom_range(0, 3));
            seg_left = $urandom_range(20, 400);
        end else begin
            seg_left--;
        end
        case (rx_mode)
            RX_OPEN:  pat = 1'b0;
            RX_HALF:  pat = 1'($urandom_range(0, 1));
            RX_LIGHT: pat = ($urandom_range(0, 7) == 0);
            default:  pat = ($urandom_range(0, 7) != 0);
        endcase
        i_stall <= pat || (hold_left != 0);
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("modular_inverse_unit_test: done, errors");
        $finish;
    end

    initial begin
        logic [WIDTH-1:0] v, m, g;
        int               k;
        fib[0] = 0;
        fib[1] = 1;
        for (int n = 2; n <= 47; n++)
            fib[n] = fib[n-1] + fib[n-2];

        // directed
        add_item(32'd0, 32'd7, 1'b0);                 // zero value
        add_item(32'd5, 32'd1, 1'b0);                 // modulus one
        add_item(32'hFFFF_FFFF, 32'd1, 1'b0);
        add_item(32'd0, 32'd1, 1'b0);
        add_item(32'd1, 32'hFFFF_FFFF, 1'b0);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0); // value equals modulus
        add_item(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0); // value above modulus
        add_item(32'd3, 32'd0, 1'b0);                 // modulus zero
        add_item(32'd3, 32'd7, 1'b0);
        add_item(32'd10, 32'd7, 1'b0);
        add_item(32'd21, 32'd7, 1'b0);                // multiple of modulus
        add_item(32'd1, 32'd2, 1'b0);
        add_item(32'd6, 32'd9, 1'b0);                 // common factor
        add_item(fib[46], fib[47], 1'b0);             // longest Euclid chain
        add_item(fib[47], fib[46], 1'b0);
        add_item(32'd2, 32'hFFFF_FFFB, 1'b0);
        add_item(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        add_item(32'h1234_5679, 32'h8000_0000, 1'b0);
        add_item(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        add_item(32'd7, 32'd7, 1'b0);
        add_item(32'h5555_5555, 32'hAAAA_AAAB, 1'b0);

        // random
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            v = $urandom;
            m = $urandom;
            case ($urandom_range(0, 19))
                10, 11: m = $urandom_range(1, 300);
                12, 13: begin
                    g = $urandom_range(2, 1000);
                    v = (v / g) * g;
                    m = (m / g) * g;
                end
                14: begin
                    k = $urandom_range(20, 46);
                    v = fib[k];
                    m = fib[k+1];
                end
                15: begin
                    case ($urandom_range(0, 5))
                        0: v = m;
                        1: v = m * $urandom_range(2, 5);
                        2: v = m - 1;
                        3: v = m + 1;
                        4: v = 0;
                        default: v = 1;
                    endcase
                end
                16, 17: m = 1 << $urandom_range(0, WIDTH - 1);
                18, 19: v = $urandom_range(0, 300);
                default: ;
            endcase
            if (m == 0)
                m = 1;
            add_item(v, m, (n % 100) == 0);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(operand_queue.size() == 0 && !i_valid && inverse_due.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0 && inverse_due.size() == 0)
            $display("modular_inverse_unit_test: done, clean");
        else
            $display("modular_inverse_unit_test: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/modinv_pkg.sv
hw/rtl/modinv_div.sv
hw/rtl/modular_inverse_unit.sv
dv/modular_inverse_unit_test.sv
